// File: src/sm4_block_cipher_ecb_ctr_core_assert.svh
// ----------------------------------------------------------------------------
// SM4 core assertion macros
// Concurrent assertion shorthands clocked on clk and disabled while arst_n is
// low. Defining NO_ASSERTIONS turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef SM4_BLOCK_CIPHER_ECB_CTR_CORE_ASSERT_SVH
`define SM4_BLOCK_CIPHER_ECB_CTR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SM4_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define SM4_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SM4_ASSERT_IMP(lbl, ante, cons, msg)
`define SM4_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/sm4_pkg.sv
// ----------------------------------------------------------------------------
// SM4 core package
// Shared constants, the controller command bundle, the S-box and the round
// function pieces used by the SM4 block cipher core.
// ----------------------------------------------------------------------------
package sm4_pkg;

	// Round count and the width of the round counter.
	localparam int ROUND_COUNT = 32;
	localparam int RND_W       = $clog2(ROUND_COUNT);

	// Field widths.
	localparam int KEY_IDX_W  = 5;
	localparam int WORD_W     = 32;
	localparam int HALF_W     = 64;
	localparam int BLOCK_W    = 2 * HALF_W;
	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 128;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// Field positions within the slave-side tdata.
	localparam int KEY_IDX_LSB  = 0;
	localparam int KEY_WORD_LSB = KEY_IDX_LSB + KEY_IDX_W;
	localparam int BLK_HI_LSB   = KEY_WORD_LSB + WORD_W;
	localparam int BLK_LO_LSB   = BLK_HI_LSB + HALF_W;

	// Item kinds carried in tuser.
	localparam logic KIND_KEY   = 1'b0;
	localparam logic KIND_BLOCK = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CTR_HI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CTR_LO = 2'd2;

	// Cipher modes.
	localparam logic MODE_ECB = 1'b0;
	localparam logic MODE_CTR = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             key_wr;
		logic             ld_block;
		logic             step;
		logic             ld_out;
		logic [RND_W-1:0] key_addr;
	} ctrl_cmd_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
		8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
		8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
		8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
		8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
		8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
		8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
		8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
		8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
		8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
		8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
		8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
		8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
		8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
		8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
		8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
		8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
		8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
		8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
		8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
		8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
		8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
		8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
		8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
		8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
		8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
		8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
		8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
		8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
		8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
		8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
	};

	// Byte-wise S-box substitution of one word.
	function automatic logic [WORD_W-1:0] sm4_tau(input logic [WORD_W-1:0] a);
		logic [WORD_W-1:0] b;
		b = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
		return b;
	endfunction

	// Linear diffusion: XOR of the word with four left rotations.
	function automatic logic [WORD_W-1:0] sm4_lin(input logic [WORD_W-1:0] b);
		logic [WORD_W-1:0] r;
		r = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
		      ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
		return r;
	endfunction

endpackage

// File: src/sm4_block_cipher_ecb_ctr_core.sv
// ----------------------------------------------------------------------------
// SM4 block cipher core, ECB and CTR: one shared round unit, one round a cycle, but the
// final round waits until the result register is free. A block runs its 32 rounds through
// the round unit and key store; no new beat is taken until its result is loaded. Key
// loads leave the core ready for the next beat. Reset clears mode and counters; keys stay unset.
// ----------------------------------------------------------------------------
`include "sm4_block_cipher_ecb_ctr_core_assert.svh"

module sm4_block_cipher_ecb_ctr_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// key_index[4:0], key_word[36:5], block_high[100:37], block_low[164:101]
	input  logic [sm4_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic                           s_axis_tuser,
	input  logic                           s_axis_tlast,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// result_high[63:0], result_low[127:64]
	output logic [sm4_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sm4_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sm4_pkg::CFG_DATA_W-1:0] cfg_data
);

	sm4_pkg::ctrl_cmd_t cmd;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	// Round sequencer.
	sm4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (cmd)
	);

	// Key store, round unit and registers.
	sm4_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.cfg_wr   (cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_data (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

	// The core is busy once a block has started.
	`SM4_ASSERT_NXT(a_busy_after_start, cmd.ld_block, !s_axis_tready, "ready during rounds")
	// A finished block always shows up on the master side.
	`SM4_ASSERT_NXT(a_result_shown, cmd.ld_out, m_axis_tvalid, "result not presented")
	// A waiting result is never overwritten.
	`SM4_ASSERT_IMP(a_no_overwrite, cmd.ld_out, !m_axis_tvalid || m_axis_tready,
		"result overwritten")
	// A key load leaves the core ready for the next beat.
	`SM4_ASSERT_NXT(a_key_load_idle, cmd.key_wr, s_axis_tready, "key load left core busy")

endmodule

// File: src/sm4_ram.sv
// ----------------------------------------------------------------------------
// SM4 generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: src/sm4_ctrl.sv
// ----------------------------------------------------------------------------
// SM4 controller
// Sequences the 32 rounds of one block, drives the key store read address
// and owns the result valid flag of the master-side output register.
// ----------------------------------------------------------------------------
module sm4_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_kind,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output sm4_pkg::ctrl_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;
	localparam logic [sm4_pkg::RND_W-1:0] LAST_RND =
		sm4_pkg::RND_W'(sm4_pkg::ROUND_COUNT - 1);

	logic                      state_q;
	logic [sm4_pkg::RND_W-1:0] round_q;
	logic                      out_valid_q;
	logic                      accept;
	logic                      last_rnd;
	logic                      out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid & in_ready;
	assign last_rnd  = (round_q == LAST_RND);
	assign out_free  = ~out_valid_q | out_ready;

	// Commands: the final round waits until the output register can take it.
	always_comb begin
		cmd.key_wr   = accept & (in_kind == sm4_pkg::KIND_KEY);
		cmd.ld_block = accept & (in_kind == sm4_pkg::KIND_BLOCK);
		cmd.step     = (state_q == ST_RUN) & (~last_rnd | out_free);
		cmd.ld_out   = (state_q == ST_RUN) & last_rnd & out_free;
		if (state_q == ST_IDLE) begin
			cmd.key_addr = '0;
		end else if (cmd.step) begin
			cmd.key_addr = sm4_pkg::RND_W'(round_q + 1'b1);
		end else begin
			cmd.key_addr = round_q;
		end
	end

	// State, round counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					round_q <= '0;
					if (cmd.ld_block) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.ld_out) begin
						state_q <= ST_IDLE;
						round_q <= '0;
					end else if (cmd.step) begin
						round_q <= sm4_pkg::RND_W'(round_q + 1'b1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/sm4_dp.sv
// ----------------------------------------------------------------------------
// SM4 datapath
// Round key store, configuration and counter registers, the four-word round
// state with one shared round unit, and the result register.
// ----------------------------------------------------------------------------
module sm4_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sm4_pkg::ctrl_cmd_t                cmd,
	input  logic [sm4_pkg::IN_DATA_W-1:0]     in_data,
	input  logic                              in_last,
	input  logic                              cfg_wr,
	input  logic [sm4_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sm4_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [sm4_pkg::OUT_DATA_W-1:0]    out_data,
	output logic                              out_last
);

	logic                             mode_q;
	logic [sm4_pkg::HALF_W-1:0]       start_hi_q;
	logic [sm4_pkg::BLOCK_W-1:0]      ctr_q;
	logic [sm4_pkg::WORD_W-1:0]       w0_q, w1_q, w2_q, w3_q;
	logic [sm4_pkg::BLOCK_W-1:0]      mask_q;
	logic                             last_q;
	logic [sm4_pkg::OUT_DATA_W-1:0]   result_q;
	logic                             result_last_q;
	logic [sm4_pkg::KEY_IDX_W-1:0]    key_idx;
	logic [sm4_pkg::WORD_W-1:0]       key_word;
	logic [sm4_pkg::BLOCK_W-1:0]      blk;
	logic [sm4_pkg::WORD_W-1:0]       rk;
	logic [sm4_pkg::WORD_W-1:0]       new_w;
	logic [sm4_pkg::BLOCK_W-1:0]      cipher_out;

	assign key_idx  = in_data[sm4_pkg::KEY_IDX_LSB +: sm4_pkg::KEY_IDX_W];
	assign key_word = in_data[sm4_pkg::KEY_WORD_LSB +: sm4_pkg::WORD_W];
	assign blk      = {in_data[sm4_pkg::BLK_HI_LSB +: sm4_pkg::HALF_W],
	                   in_data[sm4_pkg::BLK_LO_LSB +: sm4_pkg::HALF_W]};

	// Round key store, read one round ahead by the controller.
	sm4_ram #(
		.WIDTH(sm4_pkg::WORD_W),
		.DEPTH(sm4_pkg::ROUND_COUNT)
	) u_key_ram (
		.clk    (clk),
		.wr_en  (cmd.key_wr),
		.wr_addr(key_idx),
		.wr_data(key_word),
		.rd_addr(cmd.key_addr),
		.rd_data(rk)
	);

	// One SM4 round and the reversed, masked output of the final state.
	assign new_w      = w0_q ^ sm4_pkg::sm4_lin(sm4_pkg::sm4_tau(w1_q ^ w2_q ^ w3_q ^ rk));
	assign cipher_out = {new_w, w3_q, w2_q, w1_q} ^ mask_q;

	// Configuration registers and the running counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= sm4_pkg::MODE_ECB;
			start_hi_q <= '0;
			ctr_q      <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				sm4_pkg::CFG_MODE:   mode_q     <= cfg_data[0];
				sm4_pkg::CFG_CTR_HI: start_hi_q <= cfg_data;
				sm4_pkg::CFG_CTR_LO: ctr_q      <= {start_hi_q, cfg_data};
				default: ;
			endcase
		end else if (cmd.ld_block && (mode_q == sm4_pkg::MODE_CTR)) begin
			ctr_q <= ctr_q + 1'b1;
		end
	end

	// Round state, keystream mask and result register.
	always_ff @(posedge clk) begin
		if (cmd.ld_block) begin
			if (mode_q == sm4_pkg::MODE_CTR) begin
				{w0_q, w1_q, w2_q, w3_q} <= ctr_q;
				mask_q                   <= blk;
			end else begin
				{w0_q, w1_q, w2_q, w3_q} <= blk;
				mask_q                   <= '0;
			end
			last_q <= in_last;
		end else if (cmd.step) begin
			w0_q <= w1_q;
			w1_q <= w2_q;
			w2_q <= w3_q;
			w3_q <= new_w;
		end
		if (cmd.ld_out) begin
			result_q      <= cipher_out;
			result_last_q <= last_q;
		end
	end

	// Result high half sits in the low bits of tdata.
	assign out_data = {result_q[sm4_pkg::HALF_W-1:0],
	                   result_q[sm4_pkg::BLOCK_W-1:sm4_pkg::HALF_W]};
	assign out_last = result_last_q;

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// SM4 ECB/CTR core testbench
// Drives key loads and data blocks into the core and holds a cycle-free model
// of the cipher with its own key store, mode and running counter. Each block
// beat that the core accepts yields one expected result. The checker compares
// every result beat with the oldest expected result, field by field. Directed
// tests cover the data and counter extremes, counter carry and wrap, a
// counter-high write without a reload, the spare register index and decryption
// with reversed keys. Random phases then run messages with random content
// under new settings. The sender works in bursts and the receiver stalls on a
// pattern of its own.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sm4_pkg::*;

	// Run control. A drain waits until every owed result has come and then idles for
	// DRAIN_CYCLES, which covers a key load or a block still in flight.
	localparam int DRAIN_CYCLES   = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ITEM_TARGET    = 1750;

	// Register index past the last real register; writes to it are ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// Byte substitution table of the cipher.
	localparam logic [7:0] sbox_lut [256] = '{
		8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
		8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
		8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
		8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
		8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
		8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
		8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
		8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
		8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
		8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
		8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
		8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
		8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
		8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
		8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
		8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
		8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
		8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
		8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
		8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
		8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
		8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
		8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
		8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
		8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
		8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
		8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
		8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
		8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
		8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
		8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
	};

	// One expected result beat.
	typedef struct {
		logic [HALF_W-1:0] high;
		logic [HALF_W-1:0] low;
		logic              last;
	} cipher_result_t;

	// Clock, reset and the ports of the core.
	logic                  clk = 1'b0;
	logic                  arst_n;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  s_axis_tlast;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Model state: key store, mode, counter start registers and running counter.
	logic [WORD_W-1:0]  round_keys [ROUND_COUNT];
	logic               mode_reg;
	logic [HALF_W-1:0]  ctr_start_high;
	logic [HALF_W-1:0]  ctr_start_low;
	logic [BLOCK_W-1:0] ctr_running;

	// Results still owed by the core, oldest first.
	cipher_result_t expected_blocks [$];

	int error_count   = 0;
	int items_sent    = 0;
	int burst_left    = 0;
	int idle_cycles   = 0;
	bit hold_request  = 1'b0;

	always #1 clk = ~clk;

	sm4_block_cipher_ecb_ctr_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Cipher model: substitution, diffusion and the 32 rounds.
	function automatic logic [WORD_W-1:0] sbox_word(input logic [WORD_W-1:0] a);
		return {sbox_lut[a[31:24]], sbox_lut[a[23:16]], sbox_lut[a[15:8]], sbox_lut[a[7:0]]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int s);
		return (v << s) | (v >> (WORD_W - s));
	endfunction

	function automatic logic [WORD_W-1:0] diffuse(input logic [WORD_W-1:0] b);
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	function automatic logic [BLOCK_W-1:0] encrypt_block(input logic [BLOCK_W-1:0] blk);
		logic [WORD_W-1:0] w0, w1, w2, w3, nw;
		w0 = blk[127:96];
		w1 = blk[95:64];
		w2 = blk[63:32];
		w3 = blk[31:0];
		for (int r = 0; r < ROUND_COUNT; r++) begin
			nw = w0 ^ diffuse(sbox_word(w1 ^ w2 ^ w3 ^ round_keys[r]));
			w0 = w1;
			w1 = w2;
			w2 = w3;
			w3 = nw;
		end
		return {w3, w2, w1, w0};
	endfunction

	// Random half-block: mostly uniform, sometimes an extreme pattern.
	function automatic logic [HALF_W-1:0] rand_half();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return {$urandom_range(0, 1) ? 32'haaaa_aaaa : 32'h5555_5555, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Waits until every expected result has come and the core has settled.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_blocks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes one register while the core is idle and updates the model.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MODE:   mode_reg = value[0];
			CFG_CTR_HI: ctr_start_high = value;
			CFG_CTR_LO: begin
				ctr_start_low = value;
				ctr_running   = {ctr_start_high, value};
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Sends one beat in the sender's burst pattern and predicts its effect.
	task automatic send_item(input logic kind, input logic [KEY_IDX_W-1:0] idx,
			input logic [WORD_W-1:0] word, input logic [HALF_W-1:0] hi,
			input logic [HALF_W-1:0] lo, input logic last);
		int gap;
		logic [BLOCK_W-1:0] res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0
				: $urandom_range(1, ($urandom_range(0, 4) == 0) ? 45 : 4);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tlast  <= last;
		s_axis_tdata  <= {3'b000, lo, hi, word, idx};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (kind == KIND_KEY) begin
			round_keys[idx] = word;
		end else begin
			if (mode_reg == MODE_CTR) begin
				res = encrypt_block(ctr_running) ^ {hi, lo};
				ctr_running = ctr_running + 1'b1;
			end else begin
				res = encrypt_block({hi, lo});
			end
			expected_blocks.push_back('{high: res[127:64], low: res[63:0], last: last});
		end
	endtask

	task automatic send_block(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
			input logic last);
		send_item(KIND_BLOCK, KEY_IDX_W'($urandom), $urandom, hi, lo, last);
	endtask

	// Fills the whole key store; index 0 and 31 get the extreme words.
	task automatic test_key_load();
		for (int i = 0; i < ROUND_COUNT; i++)
			send_item(KIND_KEY, KEY_IDX_W'(i),
				(i == 0) ? '0 : (i == ROUND_COUNT - 1) ? '1 : WORD_W'($urandom),
				rand_half(), rand_half(), 1'($urandom_range(0, 1)));
		// Overwriting an entry must take the newer word.
		send_item(KIND_KEY, 5'd7, $urandom, '1, '1, 1'b1);
	endtask

	// Electronic codebook blocks at the data extremes, last mark both ways.
	task automatic test_ecb_directed();
		write_reg(CFG_MODE, {63'h0, MODE_ECB});
		send_block('0, '0, 1'b0);
		send_block('1, '1, 1'b1);
		send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
		send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1);
		send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
	endtask

	// Counter mode: reload, carry into the upper half, wrap of the whole
	// counter, an upper-half write without reload and the spare index.
	task automatic test_ctr_directed();
		write_reg(CFG_MODE, {63'h0, MODE_CTR});
		write_reg(CFG_CTR_HI, '0);
		write_reg(CFG_CTR_LO, '0);
		send_block('0, '0, 1'b0);
		send_block('1, '1, 1'b1);
		write_reg(CFG_CTR_HI, {$urandom, $urandom});
		write_reg(CFG_CTR_LO, 64'hffff_ffff_ffff_fffe);
		send_block(rand_half(), rand_half(), 1'b0);
		send_block(rand_half(), rand_half(), 1'b0);
		send_block(rand_half(), rand_half(), 1'b1);
		write_reg(CFG_CTR_HI, '1);
		write_reg(CFG_CTR_LO, '1);
		send_block('0, '0, 1'b0);
		send_block('0, '0, 1'b1);
		// The running counter must carry on from here, not restart.
		write_reg(CFG_CTR_HI, 64'h1234_5678_9abc_def0);
		send_block(rand_half(), rand_half(), 1'b1);
		write_reg(CFG_SPARE, '1);
		send_block(rand_half(), rand_half(), 1'b1);
	endtask

	// Loads the keys in reverse and feeds back a ciphertext: the core must
	// return the original plaintext.
	task automatic test_decrypt();
		logic [WORD_W-1:0] saved [ROUND_COUNT];
		logic [BLOCK_W-1:0] cipher;
		write_reg(CFG_MODE, {63'h0, MODE_ECB});
		saved  = round_keys;
		cipher = encrypt_block(128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210);
		for (int i = 0; i < ROUND_COUNT; i++)
			send_item(KIND_KEY, KEY_IDX_W'(i), saved[ROUND_COUNT - 1 - i], '0, '0, 1'b0);
		send_block(cipher[127:64], cipher[63:0], 1'b1);
	endtask

	// The receiver holds off for a long stretch while blocks keep coming,
	// so the core fills up and stalls its input.
	task automatic test_backpressure();
		drain();
		hold_request = 1'b1;
		burst_left   = 20;
		for (int i = 0; i < 8; i++)
			send_block(rand_half(), rand_half(), (i == 7));
		drain();
	endtask

	// Random phases: new settings, then messages with random content and the
	// odd key load between blocks.
	task automatic test_random();
		int msg_count, msg_len;
		while (items_sent < ITEM_TARGET) begin
			write_reg(CFG_MODE, {CFG_DATA_W'($urandom) << 1}
				| CFG_DATA_W'($urandom_range(0, 1)));
			case ($urandom_range(0, 5))
				0: begin
					write_reg(CFG_CTR_HI, $urandom_range(0, 1) ? '1 : '0);
					write_reg(CFG_CTR_LO, {CFG_DATA_W{1'b1}}
						- CFG_DATA_W'($urandom_range(0, 3)));
				end
				1: write_reg(CFG_CTR_HI, rand_half());
				2: write_reg(CFG_SPARE, rand_half());
				default: begin
					write_reg(CFG_CTR_HI, rand_half());
					write_reg(CFG_CTR_LO, rand_half());
				end
			endcase
			msg_count = $urandom_range(1, 6);
			for (int m = 0; m < msg_count; m++) begin
				msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
					: $urandom_range(1, 8);
				for (int b = 0; b < msg_len; b++) begin
					if ($urandom_range(0, 7) == 0)
						send_item(KIND_KEY, KEY_IDX_W'($urandom), $urandom,
							rand_half(), rand_half(), 1'($urandom_range(0, 1)));
					send_block(rand_half(), rand_half(),
						(b == msg_len - 1) ^ ($urandom_range(0, 15) == 0));
				end
			end
		end
	endtask

	// Stimulus sequence.
	initial begin
		arst_n        = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = KIND_KEY;
		s_axis_tlast  = 1'b0;
		s_axis_tvalid = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_MODE;
		cfg_data      = '0;
		mode_reg       = MODE_ECB;
		ctr_start_high = '0;
		ctr_start_low  = '0;
		ctr_running    = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_key_load();
		test_ecb_directed();
		test_ctr_directed();
		test_decrypt();
		test_backpressure();
		test_random();
		drain();
		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Receiver: a long hold-off on request, otherwise stretches of
	// always-ready, random and toggling tready.
	initial begin : result_sink
		int hold_left, stretch, style;
		hold_left = 0;
		stretch   = 0;
		style     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (stretch == 0) begin
					stretch = $urandom_range(10, 200);
					style   = $urandom_range(0, 3);
				end
				stretch--;
				case (style)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) != 0);
					default: m_axis_tready <= stretch[0];
				endcase
			end
		end
	end

	// Each result beat is compared with the oldest expected result.
	always @(posedge clk) begin : result_check
		cipher_result_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_blocks.size() == 0) begin
				error_count++;
				$display("%t unexpected result: expected none, got high %h low %h last %b",
					$time, m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tlast);
			end else begin
				exp_res = expected_blocks.pop_front();
				if (m_axis_tdata[63:0] !== exp_res.high) begin
					error_count++;
					$display("%t result_high mismatch: expected %h, got %h",
						$time, exp_res.high, m_axis_tdata[63:0]);
				end
				if (m_axis_tdata[127:64] !== exp_res.low) begin
					error_count++;
					$display("%t result_low mismatch: expected %h, got %h",
						$time, exp_res.low, m_axis_tdata[127:64]);
				end
				if (m_axis_tlast !== exp_res.last) begin
					error_count++;
					$display("%t result_last mismatch: expected %b, got %b",
						$time, exp_res.last, m_axis_tlast);
				end
			end
		end
	end

	// Watchdog: ends the run when no beat of any kind moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%t watchdog: no beat for %0d cycles", $time, idle_cycles);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

endmodule
